>>> src/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared widths, reset values and controller/datapath interface types for the
// best rational approximation block.
// ----------------------------------------------------------------------------
package bra_pkg;

    // Result field widths
    localparam int NUM_W = 28;
    localparam int DEN_W = 12;

    // Walk denominators reach the sum of two in-range bounds
    localparam int WALK_W = DEN_W + 1;

    // Default fixed-point format of the input value
    localparam int FRACTION_BITS_DEF = 32;
    localparam int INTEGER_BITS_DEF  = 16;

    // Reset value of the denominator bound
    localparam logic [DEN_W-1:0] BOUND_RESET = DEN_W'(200);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new input item and seed the walk
        logic step;   // advance the walk or latch the final fraction
        logic emit;   // write the result into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic finish; // walk ends in this cycle
    } dp_stat_t;

endpackage

>>> src/bra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_dp
// Datapath: bound register, Stern-Brocot mediant walk with incremental
// error terms, result selection and numerator fold-in.
// ----------------------------------------------------------------------------
module bra_dp #(
    parameter int FRACTION_BITS = bra_pkg::FRACTION_BITS_DEF,
    parameter int INTEGER_BITS  = bra_pkg::INTEGER_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bra_pkg::DEN_W-1:0]             max_denominator,
    input  logic [INTEGER_BITS+FRACTION_BITS-1:0] value,
    input  bra_pkg::dp_cmd_t                      cmd,
    output bra_pkg::dp_stat_t                     stat,
    output logic [bra_pkg::NUM_W-1:0]             numerator,
    output logic [bra_pkg::DEN_W-1:0]             denominator
);
    import bra_pkg::*;

    // Error terms are bounded by 2^FRACTION_BITS
    localparam int ERR_W = FRACTION_BITS + 1;
    localparam int PRD_W = INTEGER_BITS + DEN_W + 1;
    localparam int EXT_W = (PRD_W > NUM_W) ? PRD_W : NUM_W;

    logic [DEN_W-1:0]        bound_reg;
    logic [INTEGER_BITS-1:0] ip_reg;
    // elo = f*b - a*2^FB, ehi = c*2^FB - f*d
    logic [ERR_W-1:0]        elo_reg;
    logic [ERR_W-1:0]        ehi_reg;
    logic [WALK_W-1:0]       a_reg;
    logic [WALK_W-1:0]       b_reg;
    logic [WALK_W-1:0]       c_reg;
    logic [WALK_W-1:0]       d_reg;
    logic [DEN_W-1:0]        rn_reg;
    logic [DEN_W-1:0]        rd_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;

    logic [ERR_W-1:0]        frac_ext;
    logic [WALK_W-1:0]       bound_ext;
    logic [WALK_W-1:0]       p;
    logic [WALK_W-1:0]       q;
    logic                    in_range;
    logic                    err_gt;
    logic                    err_eq;
    logic [DEN_W-1:0]        rn_next;
    logic [DEN_W-1:0]        rd_next;
    logic [EXT_W-1:0]        sum_ext;

    // Walk step logic
    always_comb
    begin
        frac_ext  = ERR_W'(value[FRACTION_BITS-1:0]);
        bound_ext = WALK_W'(bound_reg);
        p         = a_reg + c_reg;
        q         = b_reg + d_reg;
        in_range  = (b_reg <= bound_ext) && (d_reg <= bound_ext);
        err_gt    = elo_reg > ehi_reg;
        err_eq    = elo_reg == ehi_reg;
        stat.finish = !in_range || err_eq;
    end

    // Pick the final fraction when the walk ends
    always_comb
    begin
        if (in_range) begin
            if (q <= bound_ext) begin
                rn_next = DEN_W'(p);
                rd_next = DEN_W'(q);
            end else if (d_reg > b_reg) begin
                rn_next = DEN_W'(c_reg);
                rd_next = DEN_W'(d_reg);
            end else begin
                rn_next = DEN_W'(a_reg);
                rd_next = DEN_W'(b_reg);
            end
        end else if (b_reg > bound_ext) begin
            rn_next = DEN_W'(c_reg);
            rd_next = DEN_W'(d_reg);
        end else begin
            rn_next = DEN_W'(a_reg);
            rd_next = DEN_W'(b_reg);
        end
    end

    // Fold the integer part into the numerator
    assign sum_ext = EXT_W'(ip_reg) * EXT_W'(rd_reg) + EXT_W'(rn_reg);

    // Hold the denominator bound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bound_reg <= BOUND_RESET;
        end else if (cfg_we) begin
            bound_reg <= max_denominator;
        end
    end

    // Seed and advance the walk
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            ip_reg  <= value[INTEGER_BITS+FRACTION_BITS-1:FRACTION_BITS];
            elo_reg <= frac_ext;
            ehi_reg <= (ERR_W'(1) << FRACTION_BITS) - frac_ext;
            a_reg   <= WALK_W'(0);
            b_reg   <= WALK_W'(1);
            c_reg   <= WALK_W'(1);
            d_reg   <= WALK_W'(1);
        end else if (cmd.step) begin
            if (stat.finish) begin
                rn_reg <= rn_next;
                rd_reg <= rd_next;
            end else if (err_gt) begin
                a_reg   <= p;
                b_reg   <= q;
                elo_reg <= elo_reg - ehi_reg;
            end else begin
                c_reg   <= p;
                d_reg   <= q;
                ehi_reg <= ehi_reg - elo_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            num_reg <= sum_ext[NUM_W-1:0];
            den_reg <= rd_reg;
        end
    end

    assign numerator   = num_reg;
    assign denominator = den_reg;

endmodule

>>> src/bra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ctrl
// Controller: accepts an item, runs the mediant walk until the datapath
// reports the end, then moves the result into the output register.
// ----------------------------------------------------------------------------
module bra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bra_pkg::dp_stat_t stat,
    output bra_pkg::dp_cmd_t  cmd
);
    import bra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode commands and next state
    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.emit       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.finish) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/best_rational_approximation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_rational_approximation
// Best rational approximation of an unsigned fixed-point value by a
// Stern-Brocot mediant walk bounded by a configurable denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one value per item (unsigned,
//   INTEGER_BITS integer and FRACTION_BITS fraction bits). Output channel
//   out_valid/out_ready carries numerator/denominator, one result per item.
//   max_denominator is written when cfg_we is high; write only while idle.
// Walk and throughput:
//   The walk takes k mediant steps, one per cycle, where k is at most about
//   max_denominator (up to 4095 for values near a whole number). The final
//   fraction is then latched and the result moved to the output register.
//   The walk loop is the limit: one subtract-and-compare of the error terms
//   per cycle. One item is in the walk at a time; the next is accepted once
//   the previous result has been moved to the output register.
// Reset:
//   rst_n clears the controller and output valid and sets the bound to 200.
// Stall:
//   A result waits in the output register while out_ready is low; a new
//   item may be accepted and walked meanwhile, then waits for the slot.
// ----------------------------------------------------------------------------
module best_rational_approximation #(
    parameter int FRACTION_BITS = bra_pkg::FRACTION_BITS_DEF,
    parameter int INTEGER_BITS  = bra_pkg::INTEGER_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bra_pkg::DEN_W-1:0]             max_denominator,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [INTEGER_BITS+FRACTION_BITS-1:0] value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bra_pkg::NUM_W-1:0]             numerator,
    output logic [bra_pkg::DEN_W-1:0]             denominator
);
    import bra_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Walk controller
    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Walk datapath
    bra_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .INTEGER_BITS  (INTEGER_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .max_denominator (max_denominator),
        .value           (value),
        .cmd             (cmd),
        .stat            (stat),
        .numerator       (numerator),
        .denominator     (denominator)
    );

`ifndef SYNTHESIS
    // One item at a time: an accepted item closes the input until it is done
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted while walk busy");

    // A delivered result never has a zero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> denominator != '0)
    else $error("zero denominator in result");

    // Datapath only loads while the controller is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_ready && !cmd.step && !cmd.emit)
    else $error("load issued outside idle");
`endif

endmodule
